>>> sv/qeit_pkg.sv
// Package for the quad edge intersection test block.
// Holds the sequencer state type, operation codes, counter constants and
// the control structs passed between the pipeline stages. No dependencies.
package qeit_pkg;

  localparam int CNT_W = 5;

  // PAIRS edge pairs are issued; the counter runs on to FIN_CNT so the
  // last pair can pass both pipeline stages and reach the hit accumulator.
  localparam logic [CNT_W-1:0] PAIRS   = 5'd16;
  localparam logic [CNT_W-1:0] FIN_CNT = 5'd18;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic vld;
    logic box_ok;
  } pair_ctl_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } pair_res_t;

endpackage

>>> sv/qeit_quad_rot.sv
// Four-vertex rotating register for one quadrilateral.
// Depends on nothing; vertex 0 and vertex 1 always form the current edge.
module qeit_quad_rot #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         rot,
  input  logic signed [COORD_BITS-1:0] ld_x [4],
  input  logic signed [COORD_BITS-1:0] ld_y [4],
  output logic signed [COORD_BITS-1:0] v0_x,
  output logic signed [COORD_BITS-1:0] v0_y,
  output logic signed [COORD_BITS-1:0] v1_x,
  output logic signed [COORD_BITS-1:0] v1_y
);

  logic signed [COORD_BITS-1:0] vx_r [4];
  logic signed [COORD_BITS-1:0] vy_r [4];

  // Rotating by one vertex moves the next edge into the fixed slots.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        vx_r[k] <= ld_x[k];
        vy_r[k] <= ld_y[k];
      end
    end else if (rot) begin
      for (int k = 0; k < 4; k++) begin
        vx_r[k] <= vx_r[(k + 1) % 4];
        vy_r[k] <= vy_r[(k + 1) % 4];
      end
    end
  end

  assign v0_x = vx_r[0];
  assign v0_y = vy_r[0];
  assign v1_x = vx_r[1];
  assign v1_y = vy_r[1];

endmodule

>>> sv/qeit_edge_prep.sv
// First stage of the shared segment tester: bounding-box overlap and the
// coordinate differences for one edge pair. Depends on qeit_pkg.
module qeit_edge_prep
  import qeit_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           issue,
  input  logic signed [COORD_BITS-1:0]   p0_x,
  input  logic signed [COORD_BITS-1:0]   p0_y,
  input  logic signed [COORD_BITS-1:0]   p1_x,
  input  logic signed [COORD_BITS-1:0]   p1_y,
  input  logic signed [COORD_BITS-1:0]   q0_x,
  input  logic signed [COORD_BITS-1:0]   q0_y,
  input  logic signed [COORD_BITS-1:0]   q1_x,
  input  logic signed [COORD_BITS-1:0]   q1_y,
  output pair_ctl_t                      ctl,
  output logic signed [COORD_BITS:0]     d1_x,
  output logic signed [COORD_BITS:0]     d1_y,
  output logic signed [COORD_BITS:0]     d2_x,
  output logic signed [COORD_BITS:0]     d2_y,
  output logic signed [COORD_BITS:0]     e_x,
  output logic signed [COORD_BITS:0]     e_y,
  output logic signed [COORD_BITS:0]     f_x,
  output logic signed [COORD_BITS:0]     f_y,
  output logic signed [COORD_BITS:0]     g_x,
  output logic signed [COORD_BITS:0]     g_y,
  output logic signed [COORD_BITS:0]     h_x,
  output logic signed [COORD_BITS:0]     h_y
);

  localparam int DW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] pmin_x, pmax_x, pmin_y, pmax_y;
  logic signed [COORD_BITS-1:0] qmin_x, qmax_x, qmin_y, qmax_y;
  logic                         box_ok;
  pair_ctl_t                    ctl_r;
  logic signed [DW-1:0]         d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [DW-1:0]         ex_r, ey_r, fx_r, fy_r, gx_r, gy_r, hx_r, hy_r;

  always_comb begin
    pmin_x = (p0_x < p1_x) ? p0_x : p1_x;
    pmax_x = (p0_x < p1_x) ? p1_x : p0_x;
    pmin_y = (p0_y < p1_y) ? p0_y : p1_y;
    pmax_y = (p0_y < p1_y) ? p1_y : p0_y;
    qmin_x = (q0_x < q1_x) ? q0_x : q1_x;
    qmax_x = (q0_x < q1_x) ? q1_x : q0_x;
    qmin_y = (q0_y < q1_y) ? q0_y : q1_y;
    qmax_y = (q0_y < q1_y) ? q1_y : q0_y;
    // Inclusive overlap: boxes that only touch still pass.
    box_ok = !(pmax_x < qmin_x) && !(pmin_x > qmax_x) &&
             !(pmax_y < qmin_y) && !(pmin_y > qmax_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.vld    <= issue;
      ctl_r.box_ok <= box_ok;
    end
  end

  always_ff @(posedge clk) begin
    d1x_r <= DW'(p1_x) - DW'(p0_x);
    d1y_r <= DW'(p1_y) - DW'(p0_y);
    d2x_r <= DW'(q1_x) - DW'(q0_x);
    d2y_r <= DW'(q1_y) - DW'(q0_y);
    ex_r  <= DW'(p0_x) - DW'(q0_x);
    ey_r  <= DW'(p0_y) - DW'(q0_y);
    fx_r  <= DW'(p1_x) - DW'(q0_x);
    fy_r  <= DW'(p1_y) - DW'(q0_y);
    gx_r  <= DW'(q0_x) - DW'(p0_x);
    gy_r  <= DW'(q0_y) - DW'(p0_y);
    hx_r  <= DW'(q1_x) - DW'(p0_x);
    hy_r  <= DW'(q1_y) - DW'(p0_y);
  end

  assign ctl  = ctl_r;
  assign d1_x = d1x_r;
  assign d1_y = d1y_r;
  assign d2_x = d2x_r;
  assign d2_y = d2y_r;
  assign e_x  = ex_r;
  assign e_y  = ey_r;
  assign f_x  = fx_r;
  assign f_y  = fy_r;
  assign g_x  = gx_r;
  assign g_y  = gy_r;
  assign h_x  = hx_r;
  assign h_y  = hy_r;

endmodule

>>> sv/qeit_cross.sv
// Second stage of the shared segment tester: four cross products at full
// width and the two-sided straddle decision. Depends on qeit_pkg.
module qeit_cross
  import qeit_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pair_ctl_t                  ctl,
  input  logic signed [COORD_BITS:0] d1_x,
  input  logic signed [COORD_BITS:0] d1_y,
  input  logic signed [COORD_BITS:0] d2_x,
  input  logic signed [COORD_BITS:0] d2_y,
  input  logic signed [COORD_BITS:0] e_x,
  input  logic signed [COORD_BITS:0] e_y,
  input  logic signed [COORD_BITS:0] f_x,
  input  logic signed [COORD_BITS:0] f_y,
  input  logic signed [COORD_BITS:0] g_x,
  input  logic signed [COORD_BITS:0] g_y,
  input  logic signed [COORD_BITS:0] h_x,
  input  logic signed [COORD_BITS:0] h_y,
  output pair_res_t                  res
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic signed [XW-1:0] cr_a, cr_b, cr_c, cr_d;
  logic                 ab_ok, cd_ok;
  pair_res_t            res_r;

  always_comb begin
    cr_a = XW'(PW'(e_x) * PW'(d2_y)) - XW'(PW'(d2_x) * PW'(e_y));
    cr_b = XW'(PW'(d2_x) * PW'(f_y)) - XW'(PW'(f_x) * PW'(d2_y));
    cr_c = XW'(PW'(g_x) * PW'(d1_y)) - XW'(PW'(d1_x) * PW'(g_y));
    cr_d = XW'(PW'(d1_x) * PW'(h_y)) - XW'(PW'(h_x) * PW'(d1_y));
    // A product is non-negative when either factor is zero or signs agree.
    ab_ok = (cr_a == '0) || (cr_b == '0) || (cr_a[XW-1] == cr_b[XW-1]);
    cd_ok = (cr_c == '0) || (cr_d == '0) || (cr_c[XW-1] == cr_d[XW-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r.vld <= ctl.vld;
      res_r.hit <= ctl.box_ok && ab_ok && cd_ok;
    end
  end

  assign res = res_r;

endmodule

>>> sv/quad_edge_intersection_test_top.sv
// Top level of the quad edge intersection test block: sequencer, reference
// quad storage and result register. Depends on qeit_pkg and the submodules.

// A load transaction stores the reference quadrilateral and returns no
// result. A test transaction is taken in, then one shared two-stage
// segment tester (box check, then four full-width cross products) is fed
// one edge pair per cycle for all 16 pairs; the hit result is accumulated
// behind the two pipeline stages, and the block takes no new transaction
// while a test is running. The result is held in an output register until
// taken; a finished test waits in the hold state if the previous result
// is still pending.
module quad_edge_intersection_test_top
  import qeit_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic signed [COORD_BITS-1:0] in_x0,
  input  logic signed [COORD_BITS-1:0] in_y0,
  input  logic signed [COORD_BITS-1:0] in_x1,
  input  logic signed [COORD_BITS-1:0] in_y1,
  input  logic signed [COORD_BITS-1:0] in_x2,
  input  logic signed [COORD_BITS-1:0] in_y2,
  input  logic signed [COORD_BITS-1:0] in_x3,
  input  logic signed [COORD_BITS-1:0] in_y3,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);

  localparam int DW = COORD_BITS + 1;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         acc_r, acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic signed [COORD_BITS-1:0] ref_x_r [4];
  logic signed [COORD_BITS-1:0] ref_y_r [4];
  logic signed [COORD_BITS-1:0] tst_x [4];
  logic signed [COORD_BITS-1:0] tst_y [4];

  logic in_fire, test_start, load_start, issue, fin_fire;

  logic signed [COORD_BITS-1:0] p0_x, p0_y, p1_x, p1_y;
  logic signed [COORD_BITS-1:0] q0_x, q0_y, q1_x, q1_y;
  pair_ctl_t                    pctl;
  pair_res_t                    pres;
  logic signed [DW-1:0]         d1_x, d1_y, d2_x, d2_y;
  logic signed [DW-1:0]         e_x, e_y, f_x, f_y, g_x, g_y, h_x, h_y;

  always_comb begin
    tst_x[0] = in_x0;
    tst_y[0] = in_y0;
    tst_x[1] = in_x1;
    tst_y[1] = in_y1;
    tst_x[2] = in_x2;
    tst_y[2] = in_y2;
    tst_x[3] = in_x3;
    tst_y[3] = in_y3;
  end

  // Output decode of the sequencer.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    in_fire    = in_valid && in_ready;
    test_start = in_fire && (in_operation == OP_TEST);
    load_start = in_fire && (in_operation == OP_LOAD);
    issue      = (state_r == ST_RUN) && (cnt_r < PAIRS);
    fin_fire   = ((state_r == ST_RUN) && (cnt_r == FIN_CNT) &&
                  (!out_valid_r || out_ready)) ||
                 ((state_r == ST_HOLD) && out_ready);
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_operation == OP_TEST)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == FIN_CNT) begin
          state_nxt = (!out_valid_r || out_ready) ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    if (test_start) begin
      cnt_nxt = '0;
      acc_nxt = 1'b0;
    end else if ((state_r == ST_RUN) && (cnt_r != FIN_CNT)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (pres.vld && pres.hit) begin
        acc_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
      out_hit_nxt   = acc_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
  end

  // The reference quad sits at the origin until the first load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        ref_x_r[k] <= '0;
        ref_y_r[k] <= '0;
      end
    end else if (load_start) begin
      for (int k = 0; k < 4; k++) begin
        ref_x_r[k] <= tst_x[k];
        ref_y_r[k] <= tst_y[k];
      end
    end
  end

  // Test edge steps every cycle while pairs are issued; reference edge steps after each four pairs.
  qeit_quad_rot #(.COORD_BITS(COORD_BITS)) u_ref_rot (
    .clk  (clk),
    .load (test_start),
    .rot  (issue && (cnt_r[1:0] == 2'd3)),
    .ld_x (ref_x_r),
    .ld_y (ref_y_r),
    .v0_x (p0_x),
    .v0_y (p0_y),
    .v1_x (p1_x),
    .v1_y (p1_y)
  );

  qeit_quad_rot #(.COORD_BITS(COORD_BITS)) u_tst_rot (
    .clk  (clk),
    .load (test_start),
    .rot  (issue),
    .ld_x (tst_x),
    .ld_y (tst_y),
    .v0_x (q0_x),
    .v0_y (q0_y),
    .v1_x (q1_x),
    .v1_y (q1_y)
  );

  qeit_edge_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .p0_x  (p0_x),
    .p0_y  (p0_y),
    .p1_x  (p1_x),
    .p1_y  (p1_y),
    .q0_x  (q0_x),
    .q0_y  (q0_y),
    .q1_x  (q1_x),
    .q1_y  (q1_y),
    .ctl   (pctl),
    .d1_x  (d1_x),
    .d1_y  (d1_y),
    .d2_x  (d2_x),
    .d2_y  (d2_y),
    .e_x   (e_x),
    .e_y   (e_y),
    .f_x   (f_x),
    .f_y   (f_y),
    .g_x   (g_x),
    .g_y   (g_y),
    .h_x   (h_x),
    .h_y   (h_y)
  );

  qeit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .d1_x  (d1_x),
    .d1_y  (d1_y),
    .d2_x  (d2_x),
    .d2_y  (d2_y),
    .e_x   (e_x),
    .e_y   (e_y),
    .f_x   (f_x),
    .f_y   (f_y),
    .g_x   (g_x),
    .g_y   (g_y),
    .h_x   (h_x),
    .h_y   (h_y),
    .res   (pres)
  );

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  a_test_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    test_start |=> ((state_r == ST_RUN) && (cnt_r == '0)))
    else $error("test transaction did not start the pair sequence");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r <= FIN_CNT))
    else $error("pair counter ran past the drain point");

  a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (pctl.vld || pres.vld) |-> (state_r == ST_RUN))
    else $error("edge pair in flight outside a test");

endmodule
